### rtl/core/mdlh_pkg.sv
package mdlh_pkg;

  localparam int DIST_BINS      = 2048;
  localparam int LEN_BINS       = 2048;
  localparam int NUM_DIST_SEG   = 6;
  localparam int NUM_LEN_SEG    = 3;
  localparam int NUM_DIST_EDGE  = NUM_DIST_SEG - 1;
  localparam int NUM_LEN_EDGE   = NUM_LEN_SEG - 1;
  localparam int LEN_FINE_DEPTH = LEN_BINS + 2;
  localparam int KB_SHIFT       = 10;

  localparam int CNT_W       = 32;
  localparam int DIST_EDGE_W = 23;
  localparam int LEN_EDGE_W  = 18;
  localparam int DIST_SEG_W  = $clog2(NUM_DIST_SEG);

  localparam int OP_W     = 2;
  localparam int OFFSET_W = 32;
  localparam int LEN_W    = 18;
  localparam int TABLE_W  = 3;
  localparam int INDEX_W  = 12;

  localparam int S_TDATA_RAW_W = OFFSET_W + LEN_W + TABLE_W + INDEX_W;
  localparam int S_TDATA_W     = ((S_TDATA_RAW_W + 7) / 8) * 8;
  localparam int M_TDATA_W     = CNT_W;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = DIST_EDGE_W;

  // Counter memory layout
  localparam int DIST_FINE_BASE = 0;
  localparam int DIST_SEG_BASE  = DIST_FINE_BASE + DIST_BINS;
  localparam int LEN_FINE_BASE  = DIST_SEG_BASE + NUM_DIST_SEG;
  localparam int LEN_SEG_BASE   = LEN_FINE_BASE + LEN_FINE_DEPTH;
  localparam int SEQ_BASE       = LEN_SEG_BASE + NUM_LEN_SEG;
  localparam int MEM_DEPTH      = SEQ_BASE + 1;
  localparam int ADDR_W         = $clog2(MEM_DEPTH);
  localparam int MAX_UPD        = 3;

  localparam logic [OP_W-1:0] OP_DIST = 2'd0;
  localparam logic [OP_W-1:0] OP_LEN  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [TABLE_W-1:0] TBL_DIST_FINE = 3'd0;
  localparam logic [TABLE_W-1:0] TBL_DIST_SEG  = 3'd1;
  localparam logic [TABLE_W-1:0] TBL_LEN_FINE  = 3'd2;
  localparam logic [TABLE_W-1:0] TBL_LEN_SEG   = 3'd3;
  localparam logic [TABLE_W-1:0] TBL_SEQ       = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_DIST_EDGE_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIST_EDGE_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIST_EDGE_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIST_EDGE_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIST_EDGE_4 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEN_EDGE_0  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEN_EDGE_1  = 3'd6;

  typedef logic [NUM_DIST_EDGE-1:0][DIST_EDGE_W-1:0] dist_edges_t;
  typedef logic [NUM_LEN_EDGE-1:0][LEN_EDGE_W-1:0]   len_edges_t;

  localparam dist_edges_t DIST_EDGE_RESET = {23'd1024, 23'd512, 23'd64, 23'd32, 23'd1};
  localparam len_edges_t  LEN_EDGE_RESET  = {18'd32, 18'd16};

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    match_length;
    logic [TABLE_W-1:0]  read_table;
    logic [INDEX_W-1:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [1:0]                     count;
    logic [MAX_UPD-1:0][ADDR_W-1:0] addr;
    logic                           is_read;
  } plan_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c == {CNT_W{1'b1}}) ? c : c + {{(CNT_W-1){1'b0}}, 1'b1};
    return r;
  endfunction

endpackage

### rtl/core/mdlh_bin.sv
module mdlh_bin (
  input  mdlh_pkg::item_t     item,
  input  mdlh_pkg::dist_edges_t dist_edge,
  input  mdlh_pkg::len_edges_t  len_edge,
  output mdlh_pkg::plan_t     plan
);

  logic [mdlh_pkg::OFFSET_W-1:0]    kb;
  logic [mdlh_pkg::DIST_EDGE_W-1:0] kb_cmp;
  logic [mdlh_pkg::DIST_SEG_W-1:0]  dseg;
  logic [1:0]                       lseg;
  logic [mdlh_pkg::ADDR_W-1:0]      lfine;
  logic [mdlh_pkg::INDEX_W-1:0]     idx;
  logic                             rd_ok;
  logic [mdlh_pkg::ADDR_W-1:0]      rd_addr;

  assign kb     = item.offset >> mdlh_pkg::KB_SHIFT;
  assign kb_cmp = mdlh_pkg::DIST_EDGE_W'(kb);
  assign idx    = item.read_index;

  // first matching edge wins
  always_comb begin
    dseg = mdlh_pkg::DIST_SEG_W'(mdlh_pkg::NUM_DIST_EDGE);
    for (int i = mdlh_pkg::NUM_DIST_EDGE - 1; i >= 0; i--) begin
      if (kb_cmp < dist_edge[i]) begin
        dseg = mdlh_pkg::DIST_SEG_W'(i);
      end
    end
  end

  always_comb begin
    if (item.match_length <= len_edge[0]) begin
      lseg = 2'd0;
    end else if (item.match_length <= len_edge[1]) begin
      lseg = 2'd1;
    end else begin
      lseg = 2'd2;
    end
    if (32'(item.match_length) <= 32'(mdlh_pkg::LEN_BINS)) begin
      lfine = mdlh_pkg::ADDR_W'(item.match_length);
    end else begin
      lfine = mdlh_pkg::ADDR_W'(mdlh_pkg::LEN_BINS + 1);
    end
  end

  always_comb begin
    rd_ok   = 1'b0;
    rd_addr = '0;
    case (item.read_table)
      mdlh_pkg::TBL_DIST_FINE: begin
        if (32'(idx) < 32'(mdlh_pkg::DIST_BINS)) begin
          rd_ok   = 1'b1;
          rd_addr = mdlh_pkg::ADDR_W'(mdlh_pkg::DIST_FINE_BASE) + mdlh_pkg::ADDR_W'(idx);
        end
      end
      mdlh_pkg::TBL_DIST_SEG: begin
        if (32'(idx) < 32'(mdlh_pkg::NUM_DIST_SEG)) begin
          rd_ok   = 1'b1;
          rd_addr = mdlh_pkg::ADDR_W'(mdlh_pkg::DIST_SEG_BASE) + mdlh_pkg::ADDR_W'(idx);
        end
      end
      mdlh_pkg::TBL_LEN_FINE: begin
        if (32'(idx) < 32'(mdlh_pkg::LEN_FINE_DEPTH)) begin
          rd_ok   = 1'b1;
          rd_addr = mdlh_pkg::ADDR_W'(mdlh_pkg::LEN_FINE_BASE) + mdlh_pkg::ADDR_W'(idx);
        end
      end
      mdlh_pkg::TBL_LEN_SEG: begin
        if (32'(idx) < 32'(mdlh_pkg::NUM_LEN_SEG)) begin
          rd_ok   = 1'b1;
          rd_addr = mdlh_pkg::ADDR_W'(mdlh_pkg::LEN_SEG_BASE) + mdlh_pkg::ADDR_W'(idx);
        end
      end
      mdlh_pkg::TBL_SEQ: begin
        if (idx == '0) begin
          rd_ok   = 1'b1;
          rd_addr = mdlh_pkg::ADDR_W'(mdlh_pkg::SEQ_BASE);
        end
      end
      default: begin
        rd_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    plan = '0;
    case (item.operation)
      mdlh_pkg::OP_DIST: begin
        plan.addr[0] = mdlh_pkg::ADDR_W'(mdlh_pkg::DIST_SEG_BASE) + mdlh_pkg::ADDR_W'(dseg);
        plan.addr[1] = mdlh_pkg::ADDR_W'(mdlh_pkg::DIST_FINE_BASE) + mdlh_pkg::ADDR_W'(kb);
        plan.count   = (kb < 32'(mdlh_pkg::DIST_BINS)) ? 2'd2 : 2'd1;
      end
      mdlh_pkg::OP_LEN: begin
        plan.addr[0] = mdlh_pkg::ADDR_W'(mdlh_pkg::SEQ_BASE);
        plan.addr[1] = mdlh_pkg::ADDR_W'(mdlh_pkg::LEN_FINE_BASE) + lfine;
        plan.addr[2] = mdlh_pkg::ADDR_W'(mdlh_pkg::LEN_SEG_BASE) + mdlh_pkg::ADDR_W'(lseg);
        plan.count   = 2'd3;
      end
      mdlh_pkg::OP_READ: begin
        plan.is_read = 1'b1;
        plan.addr[0] = rd_addr;
        plan.count   = rd_ok ? 2'd1 : 2'd0;
      end
      default: begin
        plan.count = 2'd0;
      end
    endcase
  end

endmodule

### rtl/core/match_distance_length_histogram.sv
// Match distance / length histogram engine.
// Input beats arrive on s_* : s_tuser carries the operation (record distance,
// record length, read counter); s_tdata carries, from bit 0 up, offset,
// match_length, read_table and read_index. Every input beat yields exactly one
// output beat on m_*: m_tdata is the counter value, m_tuser the read-valid flag
// (both zero for record beats and for reads of a missing bin).
// All counters live in one counter memory with a registered read; each
// update is a read, saturating increment and write-back, overlapped so that
// one update issues per cycle. A distance record makes one or two updates, a
// length record three, a read of a present bin one memory read and a read of
// a missing bin none. Each item goes from IDLE through the RUN steps to DONE,
// where its result is registered into the output beat, and then back to
// IDLE.
// One item is in flight at a time; the next beat is taken while the previous
// result still waits in the output register.
// After reset a clearing pass zeroes all 4108 counters of the memory, during
// which s_tready stays low; configuration writes are taken at any time
// and reset restores the default segment edges.
// When the receiver stalls, the finished item waits in the sequencer and the
// output beat holds until m_tready.
module match_distance_length_histogram (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // offset, match_length, read_table, read_index, zero pad
  input  logic [mdlh_pkg::S_TDATA_W-1:0]     s_tdata,
  // operation
  input  logic [mdlh_pkg::OP_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // read_value
  output logic [mdlh_pkg::M_TDATA_W-1:0]     m_tdata,
  // read_valid
  output logic                               m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mdlh_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mdlh_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                     state;
  logic [1:0]                     step;
  mdlh_pkg::plan_t                plan;
  mdlh_pkg::plan_t                plan_in;
  mdlh_pkg::item_t                item;
  mdlh_pkg::dist_edges_t          dist_edge;
  mdlh_pkg::len_edges_t           len_edge;
  logic                           pend;
  logic [mdlh_pkg::ADDR_W-1:0]    pend_addr;
  logic [mdlh_pkg::ADDR_W-1:0]    clr_addr;
  logic                           rd_en;
  logic [mdlh_pkg::ADDR_W-1:0]    rd_addr;
  logic [mdlh_pkg::CNT_W-1:0]     rdata;
  logic                           wr_en;
  logic [mdlh_pkg::ADDR_W-1:0]    wr_addr;
  logic [mdlh_pkg::CNT_W-1:0]     wr_data;
  logic                           out_free;
  logic                           rd_hit;

  logic [mdlh_pkg::CNT_W-1:0] mem [mdlh_pkg::MEM_DEPTH];

  assign item.operation    = s_tuser;
  assign item.offset       = s_tdata[mdlh_pkg::OFFSET_W-1:0];
  assign item.match_length = s_tdata[mdlh_pkg::OFFSET_W +: mdlh_pkg::LEN_W];
  assign item.read_table   = s_tdata[mdlh_pkg::OFFSET_W + mdlh_pkg::LEN_W +: mdlh_pkg::TABLE_W];
  assign item.read_index   = s_tdata[mdlh_pkg::OFFSET_W + mdlh_pkg::LEN_W + mdlh_pkg::TABLE_W
                                     +: mdlh_pkg::INDEX_W];

  mdlh_bin u_bin (
    .item      (item),
    .dist_edge (dist_edge),
    .len_edge  (len_edge),
    .plan      (plan_in)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign rd_hit    = plan.is_read && (plan.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_edge <= mdlh_pkg::DIST_EDGE_RESET;
      len_edge  <= mdlh_pkg::LEN_EDGE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mdlh_pkg::CFG_DIST_EDGE_0: dist_edge[0] <= cfg_data;
        mdlh_pkg::CFG_DIST_EDGE_1: dist_edge[1] <= cfg_data;
        mdlh_pkg::CFG_DIST_EDGE_2: dist_edge[2] <= cfg_data;
        mdlh_pkg::CFG_DIST_EDGE_3: dist_edge[3] <= cfg_data;
        mdlh_pkg::CFG_DIST_EDGE_4: dist_edge[4] <= cfg_data;
        mdlh_pkg::CFG_LEN_EDGE_0:  len_edge[0]  <= cfg_data[mdlh_pkg::LEN_EDGE_W-1:0];
        mdlh_pkg::CFG_LEN_EDGE_1:  len_edge[1]  <= cfg_data[mdlh_pkg::LEN_EDGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rd_en   = (state == ST_RUN) && (step < plan.count);
    rd_addr = plan.addr[step];
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = pend;
      wr_addr = pend_addr;
      wr_data = mdlh_pkg::sat_inc(rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      step     <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + mdlh_pkg::ADDR_W'(1);
          if (clr_addr == mdlh_pkg::ADDR_W'(mdlh_pkg::MEM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            plan  <= plan_in;
            step  <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          step      <= step + 2'd1;
          pend      <= rd_en && !plan.is_read;
          pend_addr <= rd_addr;
          if (step == plan.count) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tdata  <= rd_hit ? rdata : '0;
            m_tuser  <= rd_hit;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write-back hit the same counter in one cycle");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step <= plan.count))
    else $error("update step ran past the plan");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("input taken during clearing pass");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DONE))
    else $error("output beat raised outside completion");

  a_done_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (!wr_en && !rd_en))
    else $error("memory access while result waits");

endmodule
